>>> rtl/core/accel_limited_p_follower_assert.svh
// Assertion macros for the acceleration-limited follower.
`ifndef ACCEL_LIMITED_P_FOLLOWER_ASSERT_SVH
`define ACCEL_LIMITED_P_FOLLOWER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFL_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`define PFL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PFL_ASSERT_SAME(lbl, pre, post, msg)
`define PFL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/core/pfl_pkg.sv
// Shared types, constants and helpers of the acceleration-limited follower.
`timescale 1ns / 1ps
`default_nettype none
package pfl_pkg;
    localparam int unsigned W_REG      = 31;
    localparam int unsigned W_M        = 46;
    localparam int unsigned W_PROD     = 78;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 32;

    localparam logic [W_REG-1:0] RST_POSITION_GAIN = 31'd65536;
    localparam logic [W_REG-1:0] RST_ACCEL_LIMIT   = 31'd65536;
    localparam logic [W_REG-1:0] RST_LEAD_GAIN     = 31'd0;
    localparam logic             RST_LEAD_ENABLE   = 1'b0;
    localparam logic [W_REG-1:0] RST_TICK_PERIOD   = 31'd1092;

    typedef enum logic [2:0] {
        CFG_POSITION_GAIN = 3'd0,
        CFG_ACCEL_LIMIT   = 3'd1,
        CFG_LEAD_GAIN     = 3'd2,
        CFG_LEAD_ENABLE   = 3'd3,
        CFG_TICK_PERIOD   = 3'd4
    } t_cfg_idx;

    typedef logic signed [31:0] t_q16;
    typedef t_q16 [2:0] t_vec3;

    typedef struct packed {
        t_q16 goal_x;
        t_q16 goal_y;
        t_q16 goal_z;
        t_q16 pos_x;
        t_q16 pos_y;
        t_q16 pos_z;
        t_q16 vel_x;
        t_q16 vel_y;
        t_q16 vel_z;
        t_q16 anchor_vx;
        t_q16 anchor_vy;
        t_q16 anchor_vz;
    } t_in_item;

    typedef struct packed {
        t_q16 new_pos_x;
        t_q16 new_pos_y;
        t_q16 new_pos_z;
        t_q16 new_vel_x;
        t_q16 new_vel_y;
        t_q16 new_vel_z;
        logic was_limited;
    } t_out_item;

    typedef struct packed {
        logic [W_REG-1:0] position_gain;
        logic [W_REG-1:0] lead_gain;
        logic             lead_enable;
    } t_cfg;

    typedef struct packed {
        t_vec3                    d;
        logic [2:0][W_PROD-1:0]   prod;
        t_vec3                    vel;
        t_vec3                    pos;
    } t_sq_side;

    typedef struct packed {
        t_vec3 d;
        t_vec3 vel;
        t_vec3 pos;
        logic  limited;
        logic  len_zero;
    } t_dv_side;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic t_q16 sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/pfl_front.sv
// Front stages: error, gains, velocity change, squares, length sum and scale products.
`timescale 1ns / 1ps
`default_nettype none
module pfl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  pfl_pkg::t_in_item           i_item,
    input  pfl_pkg::t_cfg               i_cfg,
    input  logic [pfl_pkg::W_M-1:0]     i_m,
    output logic                        o_valid,
    output logic [63:0]                 o_len2,
    output pfl_pkg::t_sq_side           o_side
);
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    pfl_pkg::t_vec3 w_goal, w_pos, w_vel, w_anc;
    pfl_pkg::t_vec3 r1_e, r1_anc, r1_vel, r1_pos, n_e;
    logic signed [63:0] r2_pg [3];
    logic signed [63:0] r2_pl [3];
    logic signed [63:0] n_pg [3];
    logic signed [63:0] n_pl [3];
    pfl_pkg::t_vec3 r2_vel, r2_pos;
    pfl_pkg::t_q16 n_s [3];
    pfl_pkg::t_q16 n_l [3];
    pfl_pkg::t_vec3 n_d, r3_d, r3_vel, r3_pos;
    logic [31:0] n_mag [3];
    logic [63:0] n_sq [3];
    logic [63:0] r4_sq [3];
    logic [55:0] n_plo [3];
    logic [55:0] r4_plo [3];
    logic [53:0] n_phi [3];
    logic [53:0] r4_phi [3];
    pfl_pkg::t_vec3 r4_d, r4_vel, r4_pos;
    logic [63:0] r5_len2;
    logic [2:0][pfl_pkg::W_PROD-1:0] r5_prod, n_prod;
    pfl_pkg::t_vec3 r5_d, r5_vel, r5_pos;

    assign w_goal = {i_item.goal_z, i_item.goal_y, i_item.goal_x};
    assign w_pos  = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
    assign w_vel  = {i_item.vel_z, i_item.vel_y, i_item.vel_x};
    assign w_anc  = {i_item.anchor_vz, i_item.anchor_vy, i_item.anchor_vx};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[i]   = pfl_pkg::sat32(64'($signed(w_goal[i])) - 64'($signed(w_pos[i])));
            n_pg[i]  = $signed(r1_e[i]) * $signed({1'b0, i_cfg.position_gain});
            n_pl[i]  = $signed(r1_anc[i]) * $signed({1'b0, i_cfg.lead_gain});
            n_s[i]   = pfl_pkg::sat32(r2_pg[i] >>> 16);
            n_l[i]   = pfl_pkg::sat32(r2_pl[i] >>> 16);
            if (i_cfg.lead_enable) begin
                n_s[i] = pfl_pkg::sat32(64'(n_s[i]) + 64'(n_l[i]));
            end
            n_d[i]   = pfl_pkg::sat32(64'(n_s[i]) - 64'($signed(r2_vel[i])));
            n_mag[i] = r3_d[i][31] ? (~r3_d[i] + 32'd1) : r3_d[i];
            n_sq[i]  = n_mag[i] * n_mag[i];
            n_plo[i] = n_mag[i] * i_m[23:0];
            n_phi[i] = n_mag[i] * i_m[pfl_pkg::W_M-1:24];
            n_prod[i] = pfl_pkg::W_PROD'(r4_plo[i])
                      + (pfl_pkg::W_PROD'(r4_phi[i]) << 24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_e   <= n_e;
            r1_anc <= w_anc;
            r1_vel <= w_vel;
            r1_pos <= w_pos;
            r2_pg  <= n_pg;
            r2_pl  <= n_pl;
            r2_vel <= r1_vel;
            r2_pos <= r1_pos;
            r3_d   <= n_d;
            r3_vel <= r2_vel;
            r3_pos <= r2_pos;
            r4_sq  <= n_sq;
            r4_plo <= n_plo;
            r4_phi <= n_phi;
            r4_d   <= r3_d;
            r4_vel <= r3_vel;
            r4_pos <= r3_pos;
            r5_len2 <= r4_sq[0] + r4_sq[1] + r4_sq[2];
            r5_prod <= n_prod;
            r5_d   <= r4_d;
            r5_vel <= r4_vel;
            r5_pos <= r4_pos;
        end
    end

    assign o_valid     = r5_valid;
    assign o_len2      = r5_len2;
    assign o_side.d    = r5_d;
    assign o_side.prod = r5_prod;
    assign o_side.vel  = r5_vel;
    assign o_side.pos  = r5_pos;
endmodule
`default_nettype wire

>>> rtl/core/pfl_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module pfl_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [63:0]        i_x,
    input  pfl_pkg::t_sq_side  i_side,
    output logic               o_valid,
    output logic [31:0]        o_root,
    output pfl_pkg::t_sq_side  o_side
);
    localparam int unsigned N = pfl_pkg::SQRT_STEPS;

    logic              r_v    [N];
    logic [63:0]       r_x    [N];
    logic [63:0]       r_res  [N];
    pfl_pkg::t_sq_side r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic              v_in;
        logic [63:0]       x_in, res_in, n_x, n_res, trial;
        pfl_pkg::t_sq_side side_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_x;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign x_in    = r_x[k-1];
            assign res_in  = r_res[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (x_in >= trial) begin
                n_x   = x_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_res[k]  <= n_res;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_res[N-1][31:0];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

>>> rtl/core/pfl_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module pfl_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][pfl_pkg::W_PROD-1:0] i_num,
    input  logic [31:0]                     i_den,
    input  pfl_pkg::t_dv_side               i_side,
    output logic                            o_valid,
    output logic [2:0][31:0]                o_quo,
    output pfl_pkg::t_dv_side               o_side
);
    localparam int unsigned N = pfl_pkg::DIV_STEPS;

    logic              r_v    [N];
    logic [2:0][31:0]  r_rem  [N];
    logic [2:0][31:0]  r_low  [N];
    logic [2:0][31:0]  r_q    [N];
    logic [31:0]       r_den  [N];
    pfl_pkg::t_dv_side r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic              v_in;
        logic [2:0][31:0]  rem_in, low_in, q_in, n_rem, n_low, n_q;
        logic [31:0]       den_in;
        logic [32:0]       trial [3];
        pfl_pkg::t_dv_side side_in;

        if (k == 0) begin : g_first
            // Upper bits start as the partial remainder; they stay below the divisor
            // whenever the quotient is used.
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = i_num[j][63:32];
                assign low_in[j] = i_num[j][31:0];
            end
            assign v_in    = i_valid;
            assign q_in    = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign q_in    = r_q[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                trial[j] = {rem_in[j], low_in[j][31]};
                n_low[j] = low_in[j] << 1;
                if (trial[j] >= {1'b0, den_in}) begin
                    n_rem[j] = 32'(trial[j] - {1'b0, den_in});
                    n_q[j]   = {q_in[j][30:0], 1'b1};
                end else begin
                    n_rem[j] = trial[j][31:0];
                    n_q[j]   = {q_in[j][30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_q[k]    <= n_q;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_q[N-1];
    assign o_side  = r_side[N-1];
endmodule
`default_nettype wire

>>> rtl/core/accel_limited_p_follower.sv
// Top level of the acceleration-limited proportional follower pipeline.
// Usage:
//  - Input channel i_in_valid / o_in_ready / i_in_item carries one control update per item:
//    goal, position, velocity and anchor velocity, signed Q16.16 on three axes.
//  - Output channel o_out_valid / i_out_ready / o_out_item returns the advanced position,
//    the new velocity and the was_limited flag for each item, in order.
//  - Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 gain, 1 accel
//    limit, 2 lead gain, 3 lead enable, 4 tick period). Write only while the pipeline is
//    empty.
//  - Throughput: one item per cycle while the output is not stalled. Pipeline: 72 register
//    stages in all: 5 front stages, 32 square-root stages (one root bit each), 32 divider
//    stages (one quotient bit each), 3 back stages.
//  - Reset (synchronous, active low) clears all valid bits and loads the register
//    defaults; payload registers are not cleared.
//  - When the receiver stalls with a result waiting, every stage holds together and
//    o_in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_limited_p_follower_assert.svh"
module accel_limited_p_follower (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pfl_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pfl_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [pfl_pkg::W_REG-1:0]   i_cfg_data
);
    // Configuration registers
    logic [pfl_pkg::W_REG-1:0] r_position_gain, r_accel_limit, r_lead_gain, r_tick_period;
    logic                      r_lead_enable;
    logic [pfl_pkg::W_M-1:0]   r_m;
    pfl_pkg::t_cfg             w_cfg;

    // Whole pipeline advances together; hold everything while a result waits.
    logic advance;
    logic r_out_valid;

    logic                    w_fr_valid;
    logic [63:0]             w_len2;
    pfl_pkg::t_sq_side       w_fr_side;
    logic                    w_sq_valid;
    logic [31:0]             w_root;
    pfl_pkg::t_sq_side       w_sq_side;
    pfl_pkg::t_dv_side       w_dv_in;
    logic                    w_dv_valid;
    logic [2:0][31:0]        w_quo;
    pfl_pkg::t_dv_side       w_dsd;

    logic signed [32:0]  n_dv [3];
    pfl_pkg::t_vec3      n_nv, n_np;
    logic signed [63:0]  n_pt [3];
    logic                r_b1_valid, r_b2_valid;
    pfl_pkg::t_vec3      r_b1_nv, r_b1_pos, r_b2_nv, r_b2_pos;
    logic                r_b1_limited, r_b2_limited;
    logic signed [63:0]  r_b2_pt [3];
    pfl_pkg::t_out_item  r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_gain <= pfl_pkg::RST_POSITION_GAIN;
            r_accel_limit   <= pfl_pkg::RST_ACCEL_LIMIT;
            r_lead_gain     <= pfl_pkg::RST_LEAD_GAIN;
            r_lead_enable   <= pfl_pkg::RST_LEAD_ENABLE;
            r_tick_period   <= pfl_pkg::RST_TICK_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfl_pkg::CFG_POSITION_GAIN: r_position_gain <= i_cfg_data;
                pfl_pkg::CFG_ACCEL_LIMIT:   r_accel_limit   <= i_cfg_data;
                pfl_pkg::CFG_LEAD_GAIN:     r_lead_gain     <= i_cfg_data;
                pfl_pkg::CFG_LEAD_ENABLE:   r_lead_enable   <= i_cfg_data[0];
                pfl_pkg::CFG_TICK_PERIOD:   r_tick_period   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Velocity change limit per tick, Q16.16; follows the registers in the next cycle.
    logic [61:0] n_m_full;
    assign n_m_full = r_accel_limit * r_tick_period;
    always_ff @(posedge i_clk) begin
        r_m <= n_m_full[61:16];
    end

    assign w_cfg.position_gain = r_position_gain;
    assign w_cfg.lead_gain     = r_lead_gain;
    assign w_cfg.lead_enable   = r_lead_enable;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;

    pfl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_cfg   (w_cfg),
        .i_m     (r_m),
        .o_valid (w_fr_valid),
        .o_len2  (w_len2),
        .o_side  (w_fr_side)
    );

    pfl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (w_fr_valid),
        .i_x     (w_len2),
        .i_side  (w_fr_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Length at or above the limit takes the scaled path; a zero length takes it only when the limit is zero.
    assign w_dv_in.d        = w_sq_side.d;
    assign w_dv_in.vel      = w_sq_side.vel;
    assign w_dv_in.pos      = w_sq_side.pos;
    assign w_dv_in.limited  = !(pfl_pkg::W_M'(w_root) < r_m);
    assign w_dv_in.len_zero = (w_root == '0);

    pfl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (w_sq_valid),
        .i_num   (w_sq_side.prod),
        .i_den   (w_root),
        .i_side  (w_dv_in),
        .o_valid (w_dv_valid),
        .o_quo   (w_quo),
        .o_side  (w_dsd)
    );

    // Back end: pick the change, new velocity, position step, saturated position.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!w_dsd.limited) begin
                n_dv[i] = 33'($signed(w_dsd.d[i]));
            end else if (w_dsd.len_zero) begin
                n_dv[i] = '0;
            end else if (w_dsd.d[i][31]) begin
                n_dv[i] = -$signed({1'b0, w_quo[i]});
            end else begin
                n_dv[i] = $signed({1'b0, w_quo[i]});
            end
            n_nv[i] = pfl_pkg::sat32(64'($signed(w_dsd.vel[i])) + 64'(n_dv[i]));
            n_pt[i] = $signed(r_b1_nv[i]) * $signed({1'b0, r_tick_period});
            n_np[i] = pfl_pkg::sat32(64'($signed(r_b2_pos[i])) + (r_b2_pt[i] >>> 16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_b1_valid  <= w_dv_valid;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b1_nv      <= n_nv;
            r_b1_pos     <= w_dsd.pos;
            r_b1_limited <= w_dsd.limited;
            r_b2_pt      <= n_pt;
            r_b2_nv      <= r_b1_nv;
            r_b2_pos     <= r_b1_pos;
            r_b2_limited <= r_b1_limited;
            r_out_item.new_pos_x   <= n_np[0];
            r_out_item.new_pos_y   <= n_np[1];
            r_out_item.new_pos_z   <= n_np[2];
            r_out_item.new_vel_x   <= r_b2_nv[0];
            r_out_item.new_vel_y   <= r_b2_nv[1];
            r_out_item.new_vel_z   <= r_b2_nv[2];
            r_out_item.was_limited <= r_b2_limited;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PFL_ASSERT_SAME(a_stall_blocks_input, r_out_valid && !i_out_ready, !o_in_ready, "input taken during output stall")
    `PFL_ASSERT_NEXT(a_stall_holds_back, r_out_valid && !i_out_ready && r_b2_valid, r_b2_valid, "back stage item lost during stall")
    `PFL_ASSERT_NEXT(a_stall_holds_result, r_out_valid && !i_out_ready, r_out_valid, "waiting result dropped")
endmodule
`default_nettype wire
